// File: rtl/core/sfrc_pkg.sv
// Shared types, byte codes and the CRC-16 byte step for the stuffed frame receiver.
// No dependencies; the top level, front end, queue and back end use this package.
package sfrc_pkg;

    localparam int FRAME_BYTES_DEF = 64;
    localparam int POS_W_MAX       = 6;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] BYTE_START   = 8'h01;
    localparam logic [7:0] BYTE_END     = 8'h03;
    localparam logic [7:0] BYTE_ESC     = 8'h10;
    localparam logic [7:0] BYTE_ESC_STA = 8'h81;
    localparam logic [7:0] BYTE_ESC_END = 8'h83;
    localparam logic [7:0] BYTE_ESC_ESC = 8'h90;
    localparam logic [7:0] TYPE_ABORT_A = 8'h14;
    localparam logic [7:0] TYPE_ABORT_B = 8'h15;
    localparam logic [7:0] TYPE_CACHE   = 8'h12;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic
    {
        CMD_WRITE,
        CMD_END
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t             kind;
        logic [POS_W_MAX-1:0]  pos;
        logic [7:0]            data;
    } cmd_t;

    typedef enum logic [2:0]
    {
        BK_IDLE,
        BK_WALK_RD,
        BK_WALK_USE,
        BK_REPLAY_RD,
        BK_REPLAY_OUT,
        BK_ERROR
    } back_state_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        logic        fb;
        crc = crc_in;
        for (int b = 7; b >= 0; b--)
        begin
            fb  = data[b] ^ crc[15];
            crc = {crc[14:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

// File: rtl/core/sfrc_rx_if.sv
// Raw link byte channel: valid/ready handshake with one received byte.
// Stands alone; used by the front end and the top level.
interface sfrc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/sfrc_frm_if.sv
// Frame result channel: valid/ready handshake with one unstuffed byte and flags.
// Stands alone; used by the back end and the top level.
interface sfrc_frm_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last;
    logic       status;
    logic       for_cache;

    modport source (output valid, output frame_byte, output last, output status,
                    output for_cache, input ready);
    modport sink   (input valid, input frame_byte, input last, input status,
                    input for_cache, output ready);
endinterface

// File: rtl/core/stuffed_frame_receiver_crc16.sv
// Top level of the stuffed frame receiver with CRC-16 check.
// Depends on sfrc_pkg, sfrc_rx_if, sfrc_frm_if, sfrc_front, sfrc_queue, sfrc_back.
//
//   channel | dir | handshake   | word
//   rx      | in  | valid/ready | rx_byte
//   frm     | out | valid/ready | frame_byte, last, status, for_cache
//
// Link bytes are taken one per cycle while the command queue has room.
// On an end byte the back end walks the store for the CRC, reading each byte in
// WALK_RD and using it in WALK_USE; a good frame is then replayed through REPLAY_RD
// and REPLAY_OUT. Bytes of the next frame queue up meanwhile.
// Reset clears framing, queue and sequencer state; the frame store holds no reset.
// A stalled frm holds the back end; a full queue then holds rx.
module stuffed_frame_receiver_crc16 #(
    parameter int FRAME_BYTES = sfrc_pkg::FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sfrc_rx_if.sink     rx,
    sfrc_frm_if.source  frm
);

    logic            push_valid;
    logic            push_ready;
    sfrc_pkg::cmd_t  push_cmd;
    logic            pop_valid;
    logic            pop_ready;
    sfrc_pkg::cmd_t  pop_cmd;

    sfrc_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    sfrc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    sfrc_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .frm       (frm)
    );

`ifndef SYNTHESIS
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> push_ready)
        else $error("command pushed into a full queue");

    a_end_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready && (pop_cmd.kind == sfrc_pkg::CMD_END)) |=> !pop_ready)
        else $error("back end kept popping after an end command");

    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        (frm.valid && frm.status) |-> (frm.last && !frm.for_cache &&
                                       (frm.frame_byte == 8'h00)))
        else $error("malformed error word");
`endif

endmodule

// File: rtl/core/sfrc_front.sv
// Front end: takes raw link bytes, tracks framing and escapes, issues store commands.
// Depends on sfrc_pkg and sfrc_rx_if.
module sfrc_front #(
    parameter int FRAME_BYTES = sfrc_pkg::FRAME_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    sfrc_rx_if.sink           rx,
    output logic              push_valid,
    input  logic              push_ready,
    output sfrc_pkg::cmd_t    push_cmd
);

    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] LIMIT = POS_W'(FRAME_BYTES - 10);

    logic [POS_W-1:0] byte_count_reg, byte_count_next;
    logic             in_frame_reg, in_frame_next;
    logic             escape_reg, escape_next;

    logic             accept;
    logic             in_frame_eff;
    logic             abort_hit;
    logic             overflow_hit;
    logic             esc_hit;
    logic [7:0]       esc_dec;

    assign rx.ready     = push_ready;
    assign accept       = rx.valid && push_ready;
    assign in_frame_eff = in_frame_reg || (rx.rx_byte == sfrc_pkg::BYTE_START);
    assign abort_hit    = (byte_count_reg == POS_W'(1)) &&
                          ((rx.rx_byte == sfrc_pkg::TYPE_ABORT_A) ||
                           (rx.rx_byte == sfrc_pkg::TYPE_ABORT_B));
    assign overflow_hit = byte_count_reg > LIMIT;

    always_comb
    begin
        esc_hit = 1'b1;
        esc_dec = 8'h00;
        case (rx.rx_byte)
            sfrc_pkg::BYTE_ESC_STA: esc_dec = sfrc_pkg::BYTE_START;
            sfrc_pkg::BYTE_ESC_END: esc_dec = sfrc_pkg::BYTE_END;
            sfrc_pkg::BYTE_ESC_ESC: esc_dec = sfrc_pkg::BYTE_ESC;
            default:                esc_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        in_frame_next   = in_frame_reg;
        escape_next     = escape_reg;
        push_valid      = 1'b0;
        push_cmd.kind   = sfrc_pkg::CMD_WRITE;
        push_cmd.pos    = sfrc_pkg::POS_W_MAX'(byte_count_reg);
        push_cmd.data   = rx.rx_byte;
        if (accept)
        begin
            if (abort_hit || overflow_hit)
            begin
                byte_count_next = '0;
                in_frame_next   = 1'b0;
                escape_next     = 1'b0;
            end
            else if (in_frame_eff)
            begin
                push_valid    = 1'b1;
                in_frame_next = 1'b1;
                if (rx.rx_byte == sfrc_pkg::BYTE_END)
                begin
                    push_cmd.kind   = sfrc_pkg::CMD_END;
                    byte_count_next = '0;
                    in_frame_next   = 1'b0;
                    escape_next     = 1'b0;
                end
                else if (escape_reg && esc_hit)
                begin
                    push_cmd.pos  = sfrc_pkg::POS_W_MAX'(byte_count_reg - POS_W'(1));
                    push_cmd.data = esc_dec;
                    escape_next   = 1'b0;
                end
                else
                begin
                    escape_next     = (rx.rx_byte == sfrc_pkg::BYTE_ESC);
                    byte_count_next = byte_count_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            in_frame_reg   <= 1'b0;
            escape_reg     <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            in_frame_reg   <= in_frame_next;
            escape_reg     <= escape_next;
        end
    end

endmodule

// File: rtl/core/sfrc_queue.sv
// Short command queue between the front end and the back end.
// Depends on sfrc_pkg.
module sfrc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  sfrc_pkg::cmd_t    push_cmd,
    output logic              pop_valid,
    input  logic              pop_ready,
    output sfrc_pkg::cmd_t    pop_cmd
);

    localparam int DEPTH = sfrc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfrc_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/sfrc_back.sv
// Back end: owns the frame store, runs the CRC walk and replays good frames.
// Depends on sfrc_pkg and sfrc_frm_if.
module sfrc_back #(
    parameter int FRAME_BYTES = sfrc_pkg::FRAME_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  sfrc_pkg::cmd_t    pop_cmd,
    sfrc_frm_if.source        frm
);

    localparam int POS_W = $clog2(FRAME_BYTES);

    logic [7:0]             store_reg [FRAME_BYTES];
    logic [7:0]             rd_data_reg;

    sfrc_pkg::back_state_t  state_reg, state_next;
    logic [POS_W-1:0]       idx_reg, idx_next;
    logic [POS_W-1:0]       end_reg, end_next;
    logic [15:0]            crc_reg, crc_next;
    logic [7:0]             rcv_lo_reg, rcv_lo_next;
    logic                   cache_reg, cache_next;

    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_byte_reg, out_byte_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_status_reg, out_status_next;
    logic                   out_cache_reg, out_cache_next;

    logic                   out_free;
    logic                   out_load;
    logic                   rd_en;
    logic                   wr_en;
    logic [POS_W-1:0]       pop_pos;
    logic [POS_W-1:0]       end_m1;
    logic [POS_W-1:0]       end_m2;
    logic                   walk_last;
    logic                   replay_last;
    logic [15:0]            rcv_word;
    logic                   frame_good;

    assign out_free    = !out_valid_reg || frm.ready;
    assign pop_pos     = pop_cmd.pos[POS_W-1:0];
    assign end_m1      = end_reg - POS_W'(1);
    assign end_m2      = end_reg - POS_W'(2);
    assign walk_last   = idx_reg == end_m1;
    assign replay_last = idx_reg == end_reg;
    assign rcv_word    = {rd_data_reg, rcv_lo_reg};
    assign frame_good  = (rcv_word == crc_reg) && (rcv_word != 16'h0000);

    assign frm.valid      = out_valid_reg;
    assign frm.frame_byte = out_byte_reg;
    assign frm.last       = out_last_reg;
    assign frm.status     = out_status_reg;
    assign frm.for_cache  = out_cache_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfrc_pkg::BK_IDLE:
            begin
                if (pop_valid && (pop_cmd.kind == sfrc_pkg::CMD_END))
                begin
                    state_next = (pop_pos < POS_W'(2)) ? sfrc_pkg::BK_ERROR
                                                       : sfrc_pkg::BK_WALK_RD;
                end
            end
            sfrc_pkg::BK_WALK_RD:
            begin
                state_next = sfrc_pkg::BK_WALK_USE;
            end
            sfrc_pkg::BK_WALK_USE:
            begin
                if (!walk_last)
                begin
                    state_next = sfrc_pkg::BK_WALK_RD;
                end
                else
                begin
                    state_next = frame_good ? sfrc_pkg::BK_REPLAY_RD : sfrc_pkg::BK_ERROR;
                end
            end
            sfrc_pkg::BK_REPLAY_RD:
            begin
                state_next = sfrc_pkg::BK_REPLAY_OUT;
            end
            sfrc_pkg::BK_REPLAY_OUT:
            begin
                if (out_free)
                begin
                    state_next = replay_last ? sfrc_pkg::BK_IDLE : sfrc_pkg::BK_REPLAY_RD;
                end
            end
            sfrc_pkg::BK_ERROR:
            begin
                if (out_free)
                begin
                    state_next = sfrc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = sfrc_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next        = idx_reg;
        end_next        = end_reg;
        crc_next        = crc_reg;
        rcv_lo_next     = rcv_lo_reg;
        cache_next      = cache_reg;
        pop_ready       = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        out_load        = 1'b0;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        out_cache_next  = out_cache_reg;
        case (state_reg)
            sfrc_pkg::BK_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    wr_en = 1'b1;
                    if (pop_cmd.kind == sfrc_pkg::CMD_END)
                    begin
                        end_next   = pop_pos;
                        idx_next   = '0;
                        crc_next   = 16'h0000;
                        cache_next = 1'b0;
                    end
                end
            end
            sfrc_pkg::BK_WALK_RD:
            begin
                rd_en = 1'b1;
            end
            sfrc_pkg::BK_WALK_USE:
            begin
                if ((idx_reg != '0) && (idx_reg < end_m2))
                begin
                    crc_next = sfrc_pkg::crc16_byte(crc_reg, rd_data_reg);
                end
                if (idx_reg == end_m2)
                begin
                    rcv_lo_next = rd_data_reg;
                end
                if (idx_reg == POS_W'(1))
                begin
                    cache_next = (rd_data_reg == sfrc_pkg::TYPE_CACHE);
                end
                idx_next = walk_last ? '0 : idx_reg + POS_W'(1);
            end
            sfrc_pkg::BK_REPLAY_RD:
            begin
                rd_en = 1'b1;
            end
            sfrc_pkg::BK_REPLAY_OUT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_byte_next   = rd_data_reg;
                    out_last_next   = replay_last;
                    out_status_next = 1'b0;
                    out_cache_next  = cache_reg;
                    idx_next        = idx_reg + POS_W'(1);
                end
            end
            sfrc_pkg::BK_ERROR:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_byte_next   = 8'h00;
                    out_last_next   = 1'b1;
                    out_status_next = 1'b1;
                    out_cache_next  = 1'b0;
                end
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !frm.ready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[pop_pos] <= pop_cmd.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[idx_reg];
        end
        if (out_load)
        begin
            out_byte_reg   <= out_byte_next;
            out_last_reg   <= out_last_next;
            out_status_reg <= out_status_next;
            out_cache_reg  <= out_cache_next;
        end
        idx_reg    <= idx_next;
        end_reg    <= end_next;
        crc_reg    <= crc_next;
        rcv_lo_reg <= rcv_lo_next;
        cache_reg  <= cache_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfrc_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: tb/stuffed_frame_receiver_crc16_tb.sv
// Testbench for stuffed_frame_receiver_crc16: drives raw link bytes, predicts unstuffed
// frames and CRC rejects, and checks every result word against the prediction.
// Depends on sfrc_pkg, sfrc_rx_if, sfrc_frm_if and the RTL top level.
`timescale 1ns / 100ps

module stuffed_frame_receiver_crc16_tb;

    localparam int FRAME_BYTES  = sfrc_pkg::FRAME_BYTES_DEF;
    localparam int DROP_ABOVE   = FRAME_BYTES - 10;
    localparam int RANDOM_ITEMS = 370;
    localparam int DIR_ROWS     = 26;

    typedef struct packed
    {
        logic [7:0] frame_byte;
        logic       last;
        logic       status;
        logic       for_cache;
    } frame_word_t;

    typedef enum logic [1:0]
    {
        CHK_MODEL,
        CHK_SILENT,
        CHK_REJECT
    } row_check_t;

    typedef struct packed
    {
        logic [7:0] raw;
        row_check_t chk;
    } stim_row_t;

    typedef enum logic [2:0]
    {
        FR_CLEAN,
        FR_BAD_CRC,
        FR_ABORT,
        FR_OVERFLOW,
        FR_LOOSE_STUFF
    } frame_kind_t;

    localparam frame_word_t REJECT_WORD = '{8'h00, 1'b1, 1'b1, 1'b0};

    logic clk = 1'b0;
    logic rst_n;

    sfrc_rx_if  rx_if ();
    sfrc_frm_if frm_if ();

    stuffed_frame_receiver_crc16 #(
        .FRAME_BYTES (FRAME_BYTES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .frm   (frm_if)
    );

    always #10 clk = ~clk;

    logic [7:0]  rx_store [0:63];
    logic [5:0]  rx_count;
    logic        rx_in_frame;
    logic        rx_escaped;
    frame_word_t expected_words [$];
    frame_word_t unstuffed_words [$];
    frame_word_t seen_word;
    frame_word_t wanted_word;
    int          mismatches    = 0;
    int          frame_items   = 0;
    int          src_idle_pct  = 12;
    int          sink_idle_pct = 60;

    stim_row_t directed_rows [DIR_ROWS] = '{
        '{8'hFF,                  CHK_SILENT},
        '{sfrc_pkg::BYTE_START,   CHK_SILENT}, '{sfrc_pkg::BYTE_END,     CHK_REJECT},
        '{sfrc_pkg::BYTE_START,   CHK_SILENT}, '{sfrc_pkg::TYPE_ABORT_A, CHK_SILENT},
        '{sfrc_pkg::BYTE_START,   CHK_SILENT}, '{sfrc_pkg::TYPE_ABORT_B, CHK_SILENT},
        '{sfrc_pkg::BYTE_START,   CHK_SILENT}, '{8'h00,                  CHK_SILENT},
        '{8'h00,                  CHK_SILENT}, '{8'h00,                  CHK_SILENT},
        '{sfrc_pkg::BYTE_END,     CHK_REJECT},
        '{sfrc_pkg::BYTE_START,   CHK_MODEL},  '{sfrc_pkg::TYPE_CACHE,   CHK_MODEL},
        '{8'h73,                  CHK_MODEL},  '{8'h32,                  CHK_MODEL},
        '{sfrc_pkg::BYTE_END,     CHK_MODEL},
        '{sfrc_pkg::BYTE_START,   CHK_MODEL},  '{sfrc_pkg::BYTE_ESC,     CHK_MODEL},
        '{sfrc_pkg::BYTE_ESC_ESC, CHK_MODEL},  '{8'h31,                  CHK_MODEL},
        '{8'h12,                  CHK_MODEL},  '{sfrc_pkg::BYTE_END,     CHK_MODEL},
        '{sfrc_pkg::BYTE_START,   CHK_SILENT}, '{sfrc_pkg::BYTE_ESC,     CHK_SILENT},
        '{sfrc_pkg::BYTE_END,     CHK_REJECT}
    };

    function automatic logic [15:0] crc16_shift(input logic [15:0] crc_in,
                                                input logic [7:0]  d);
        logic [15:0] acc;
        acc = crc_in ^ {d, 8'h00};
        repeat (8)
        begin
            acc = acc[15] ? ({acc[14:0], 1'b0} ^ sfrc_pkg::CRC_POLY) : {acc[14:0], 1'b0};
        end
        return acc;
    endfunction

    function automatic void drop_frame();
        rx_in_frame = 1'b0;
        rx_count    = '0;
        rx_escaped  = 1'b0;
    endfunction

    task automatic deframe_byte(input logic [7:0] rx);
        logic [5:0]  pos;
        logic [15:0] rcv;
        logic [15:0] calc;
        logic [7:0]  dec;
        bit          good;
        bit          hit;
        bit          cache;
        unstuffed_words.delete();
        pos = rx_count;
        if (rx == sfrc_pkg::BYTE_START)
        begin
            rx_in_frame = 1'b1;
        end
        if (rx_count == 6'd1 && (rx == sfrc_pkg::TYPE_ABORT_A || rx == sfrc_pkg::TYPE_ABORT_B))
        begin
            drop_frame();
            return;
        end
        if (int'(rx_count) > DROP_ABOVE)
        begin
            drop_frame();
            return;
        end
        if (!rx_in_frame)
        begin
            return;
        end
        rx_store[pos] = rx;
        if (rx == sfrc_pkg::BYTE_END)
        begin
            good = 1'b0;
            if (pos >= 6'd2)
            begin
                rcv  = {rx_store[pos - 6'd1], rx_store[pos - 6'd2]};
                calc = '0;
                for (int i = 1; i < int'(pos) - 2; i++)
                begin
                    calc = crc16_shift(calc, rx_store[i]);
                end
                good = (rcv == calc) && (rcv != 16'h0000);
            end
            if (good)
            begin
                cache = (rx_store[1] == sfrc_pkg::TYPE_CACHE);
                for (int i = 0; i <= int'(pos); i++)
                begin
                    unstuffed_words.push_back('{rx_store[i], (i == int'(pos)), 1'b0, cache});
                end
            end
            else
            begin
                unstuffed_words.push_back(REJECT_WORD);
            end
            drop_frame();
            return;
        end
        if (rx_escaped)
        begin
            hit = 1'b1;
            dec = 8'h00;
            case (rx)
                sfrc_pkg::BYTE_ESC_STA: dec = sfrc_pkg::BYTE_START;
                sfrc_pkg::BYTE_ESC_END: dec = sfrc_pkg::BYTE_END;
                sfrc_pkg::BYTE_ESC_ESC: dec = sfrc_pkg::BYTE_ESC;
                default:                hit = 1'b0;
            endcase
            if (hit)
            begin
                rx_store[pos - 6'd1] = dec;
                rx_escaped = 1'b0;
                return;
            end
        end
        rx_escaped = (rx == sfrc_pkg::BYTE_ESC);
        rx_count   = pos + 6'd1;
    endtask

    task automatic send_raw(input logic [7:0] b, input row_check_t chk = CHK_MODEL);
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
        begin
            @(posedge clk);
        end
        deframe_byte(b);
        frame_items++;
        case (chk)
            CHK_MODEL:
            begin
                foreach (unstuffed_words[i])
                begin
                    expected_words.push_back(unstuffed_words[i]);
                end
            end
            CHK_REJECT: expected_words.push_back(REJECT_WORD);
            default:    ;
        endcase
    endtask

    task automatic send_stuffed(input logic [7:0] b, input bit loose);
        if (!loose && b == sfrc_pkg::BYTE_START)
        begin
            send_raw(sfrc_pkg::BYTE_ESC);
            send_raw(sfrc_pkg::BYTE_ESC_STA);
        end
        else if (!loose && b == sfrc_pkg::BYTE_END)
        begin
            send_raw(sfrc_pkg::BYTE_ESC);
            send_raw(sfrc_pkg::BYTE_ESC_END);
        end
        else if (!loose && b == sfrc_pkg::BYTE_ESC)
        begin
            send_raw(sfrc_pkg::BYTE_ESC);
            send_raw(sfrc_pkg::BYTE_ESC_ESC);
        end
        else
        begin
            send_raw(b);
        end
    endtask

    task automatic send_frame(input frame_kind_t kind);
        logic [7:0]  body [$];
        logic [7:0]  t;
        logic [15:0] crc;
        int          n;
        if (kind == FR_ABORT)
        begin
            t = $urandom_range(1) ? sfrc_pkg::TYPE_ABORT_A : sfrc_pkg::TYPE_ABORT_B;
        end
        else if ($urandom_range(3) == 0)
        begin
            t = sfrc_pkg::TYPE_CACHE;
        end
        else
        begin
            do
                t = 8'($urandom_range(255));
            while (t == sfrc_pkg::TYPE_ABORT_A || t == sfrc_pkg::TYPE_ABORT_B);
        end
        if (kind == FR_OVERFLOW)
        begin
            n = $urandom_range(DROP_ABOVE - 2, FRAME_BYTES - 6);
        end
        else if ($urandom_range(19) == 0)
        begin
            n = $urandom_range(9, DROP_ABOVE - 4);
        end
        else
        begin
            n = $urandom_range(8);
        end
        body.push_back(t);
        repeat (n)
        begin
            body.push_back(8'($urandom_range(255)));
        end
        crc = '0;
        foreach (body[i])
        begin
            crc = crc16_shift(crc, body[i]);
        end
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        if (kind == FR_BAD_CRC)
        begin
            body[body.size() - 1 - $urandom_range(1)] ^= 8'($urandom_range(1, 255));
        end
        if (kind == FR_OVERFLOW)
        begin
            foreach (body[i])
            begin
                if (body[i] == sfrc_pkg::BYTE_START || body[i] == sfrc_pkg::BYTE_END
                    || body[i] == sfrc_pkg::BYTE_ESC)
                begin
                    body[i] = ~body[i];
                end
            end
            if ($urandom_range(1))
            begin
                body[DROP_ABOVE] = sfrc_pkg::BYTE_START;
            end
        end
        send_raw(sfrc_pkg::BYTE_START);
        foreach (body[i])
        begin
            if (kind == FR_LOOSE_STUFF && $urandom_range(5) == 0)
            begin
                send_raw(sfrc_pkg::BYTE_ESC);
                send_raw(8'($urandom_range(255)));
            end
            send_stuffed(body[i], kind == FR_LOOSE_STUFF && $urandom_range(3) == 0);
        end
        send_raw(sfrc_pkg::BYTE_END);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 12))
        begin
            if ($urandom_range(3) == 0)
            begin
                case ($urandom_range(3))
                    0:       send_raw(sfrc_pkg::BYTE_START);
                    1:       send_raw(sfrc_pkg::BYTE_END);
                    2:       send_raw(sfrc_pkg::BYTE_ESC);
                    default: send_raw(sfrc_pkg::BYTE_ESC_STA);
                endcase
            end
            else
            begin
                send_raw(8'($urandom_range(255)));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frm_if.ready <= 1'b0;
        end
        else
        begin
            frm_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && frm_if.valid && frm_if.ready)
        begin
            seen_word = '{frm_if.frame_byte, frm_if.last, frm_if.status, frm_if.for_cache};
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: unexpected word byte %h last %b status %b cache %b",
                             $realtime, seen_word.frame_byte, seen_word.last,
                             seen_word.status, seen_word.for_cache);
                end
            end
            else
            begin
                wanted_word = expected_words.pop_front();
                if (seen_word.frame_byte !== wanted_word.frame_byte
                    || seen_word.last !== wanted_word.last
                    || seen_word.status !== wanted_word.status
                    || seen_word.for_cache !== wanted_word.for_cache)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: expected byte %h last %b status %b cache %b, got %h %b %b %b",
                                 $realtime, wanted_word.frame_byte, wanted_word.last,
                                 wanted_word.status, wanted_word.for_cache,
                                 seen_word.frame_byte, seen_word.last,
                                 seen_word.status, seen_word.for_cache);
                    end
                end
            end
        end
    end

    initial
    begin
        int pick;
        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = 8'h00;
        drop_frame();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            send_raw(directed_rows[r].raw, directed_rows[r].chk);
        end
        while (frame_items < RANDOM_ITEMS)
        begin
            case (frame_items * 3 / RANDOM_ITEMS)
                0:
                begin
                    src_idle_pct  = 12;
                    sink_idle_pct = 60;
                end
                1:
                begin
                    src_idle_pct  = 60;
                    sink_idle_pct = 12;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            pick = $urandom_range(99);
            if (pick < 66)
            begin
                send_frame(FR_CLEAN);
            end
            else if (pick < 74)
            begin
                send_frame(FR_BAD_CRC);
            end
            else if (pick < 78)
            begin
                send_frame(FR_ABORT);
            end
            else if (pick < 82)
            begin
                send_frame(FR_OVERFLOW);
            end
            else if (pick < 90)
            begin
                send_noise();
            end
            else
            begin
                send_frame(FR_LOOSE_STUFF);
            end
        end
        rx_if.valid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
        begin
            $display("stuffed_frame_receiver_crc16_tb: clean");
        end
        else
        begin
            $display("stuffed_frame_receiver_crc16_tb: errors");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("stuffed_frame_receiver_crc16_tb: errors");
        $finish;
    end

endmodule
